/* hdl/stun_hdr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stun_hdr_pkg
// Shared types and constants of the STUN header and attribute parser.
// ----------------------------------------------------------------------------
package stun_hdr_pkg;

  localparam logic [1:0] KIND_HEADER   = 2'd0;
  localparam logic [1:0] KIND_USERNAME = 2'd1;
  localparam logic [1:0] KIND_STATUS   = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_OVERRUN = 2'd1;
  localparam logic [1:0] STATUS_SHORT   = 2'd2;

  localparam logic [15:0] METHOD_MASK      = 16'hFEEF;
  localparam logic [15:0] USERNAME_DEFAULT = 16'd6;
  localparam int          HDR_BYTES        = 20;
  localparam int          ATTR_HDR_BYTES   = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] method;
    logic [1:0]  msg_class;
    logic [31:0] trans_id_upper;
    logic [63:0] trans_id_lower;
    logic [7:0]  username_byte;
    logic        username_last;
    logic [1:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic va;
    logic vb;
    res_t a;
    res_t b;
  } push_t;

endpackage

/* hdl/stun_hdr_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stun_hdr_parse
// Per-byte parser state: header capture, attribute walk and end status.
// Produces up to two results for each accepted word.
// ----------------------------------------------------------------------------
module stun_hdr_parse #(
  parameter int MAX_DATAGRAM = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic [11:0]          packet_length,
  input  logic                 end_of_packet,
  input  logic [15:0]          username_attr_type,
  output stun_hdr_pkg::push_t  push
);

  localparam int IW = $clog2(MAX_DATAGRAM + 1);
  localparam int CW = ((IW > 16) ? IW : 16) + 2;
  localparam logic [IW-1:0] MAX_IDX = IW'(MAX_DATAGRAM);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_ATTR_HDR,
    PH_VALUE,
    PH_PAD,
    PH_DONE
  } phase_t;

  logic [IW-1:0] byte_index, byte_index_next;
  phase_t        phase, phase_next;
  logic [15:0]   type_word, type_word_next;
  logic [31:0]   tid_high, tid_high_next;
  logic [63:0]   tid_low, tid_low_next;
  logic [31:0]   attr_hdr, attr_hdr_next;
  logic [15:0]   value_rem, value_rem_next;
  logic [1:0]    pad_rem, pad_rem_next;
  logic          in_user, in_user_next;
  logic          err, err_next;

  logic [CW-1:0] len_x, max_x, len_c, idx_x;
  logic          first_v;
  stun_hdr_pkg::res_t first_r, stat_r;

  always_comb begin
    len_x = CW'(packet_length);
    max_x = CW'(MAX_DATAGRAM);
    len_c = (len_x > max_x) ? max_x : len_x;
    idx_x = CW'(byte_index);

    byte_index_next = byte_index;
    phase_next      = phase;
    type_word_next  = type_word;
    tid_high_next   = tid_high;
    tid_low_next    = tid_low;
    attr_hdr_next   = attr_hdr;
    value_rem_next  = value_rem;
    pad_rem_next    = pad_rem;
    in_user_next    = in_user;
    err_next        = err;
    first_v         = 1'b0;
    first_r         = '0;
    stat_r          = '0;
    push            = '0;

    case (phase)
      PH_HEADER: begin
        if (idx_x < CW'(2)) begin
          type_word_next = {type_word[7:0], data_byte};
        end else if (idx_x >= CW'(8) && idx_x < CW'(12)) begin
          tid_high_next = {tid_high[23:0], data_byte};
        end else if (idx_x >= CW'(12) && idx_x < CW'(stun_hdr_pkg::HDR_BYTES)) begin
          tid_low_next = {tid_low[55:0], data_byte};
        end
        if (idx_x == CW'(stun_hdr_pkg::HDR_BYTES - 1)) begin
          first_v                = 1'b1;
          first_r.kind           = stun_hdr_pkg::KIND_HEADER;
          first_r.method         = type_word & stun_hdr_pkg::METHOD_MASK;
          first_r.msg_class      = {type_word[8], type_word[4]};
          first_r.trans_id_upper = tid_high;
          first_r.trans_id_lower = {tid_low[55:0], data_byte};
          phase_next             = PH_ATTR_HDR;
        end
      end
      PH_ATTR_HDR: begin
        if (byte_index[1:0] == 2'd0 &&
            !(idx_x + CW'(stun_hdr_pkg::ATTR_HDR_BYTES) < len_c)) begin
          phase_next = PH_DONE;
        end else begin
          attr_hdr_next = (byte_index[1:0] == 2'd0) ? {24'd0, data_byte}
                                                    : {attr_hdr[23:0], data_byte};
          if (byte_index[1:0] == 2'd3) begin
            if (idx_x + CW'(1) + CW'(attr_hdr_next[15:0]) > len_c) begin
              err_next   = 1'b1;
              phase_next = PH_DONE;
            end else begin
              in_user_next   = (attr_hdr_next[31:16] == username_attr_type);
              value_rem_next = attr_hdr_next[15:0];
              pad_rem_next   = 2'd0 - attr_hdr_next[1:0];
              phase_next     = (attr_hdr_next[15:0] != 16'd0) ? PH_VALUE : PH_ATTR_HDR;
            end
          end
        end
      end
      PH_VALUE: begin
        if (in_user) begin
          first_v               = 1'b1;
          first_r.kind          = stun_hdr_pkg::KIND_USERNAME;
          first_r.username_byte = data_byte;
          first_r.username_last = (value_rem == 16'd1);
        end
        value_rem_next = value_rem - 16'd1;
        if (value_rem_next == 16'd0) begin
          phase_next = (pad_rem != 2'd0) ? PH_PAD : PH_ATTR_HDR;
        end
      end
      PH_PAD: begin
        pad_rem_next = pad_rem - 2'd1;
        if (pad_rem_next == 2'd0) begin
          phase_next = PH_ATTR_HDR;
        end
      end
      default: begin
      end
    endcase

    if (byte_index < MAX_IDX) begin
      byte_index_next = byte_index + IW'(1);
    end

    stat_r.kind = stun_hdr_pkg::KIND_STATUS;
    stat_r.last = 1'b1;
    if (idx_x < CW'(stun_hdr_pkg::HDR_BYTES - 1) ||
        len_c < CW'(stun_hdr_pkg::HDR_BYTES)) begin
      stat_r.status = stun_hdr_pkg::STATUS_SHORT;
    end else if (err_next) begin
      stat_r.status = stun_hdr_pkg::STATUS_OVERRUN;
    end else begin
      stat_r.status = stun_hdr_pkg::STATUS_OK;
    end

    first_r.last = !end_of_packet;
    if (first_v) begin
      push.va = 1'b1;
      push.a  = first_r;
      push.vb = end_of_packet;
      push.b  = stat_r;
    end else if (end_of_packet) begin
      push.va = 1'b1;
      push.a  = stat_r;
    end

    if (end_of_packet) begin
      byte_index_next = '0;
      phase_next      = PH_HEADER;
      type_word_next  = '0;
      tid_high_next   = '0;
      tid_low_next    = '0;
      attr_hdr_next   = '0;
      value_rem_next  = '0;
      pad_rem_next    = '0;
      in_user_next    = 1'b0;
      err_next        = 1'b0;
    end

    if (!accept) begin
      push.va = 1'b0;
      push.vb = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      phase      <= PH_HEADER;
      type_word  <= '0;
      tid_high   <= '0;
      tid_low    <= '0;
      attr_hdr   <= '0;
      value_rem  <= '0;
      pad_rem    <= '0;
      in_user    <= 1'b0;
      err        <= 1'b0;
    end else if (accept) begin
      byte_index <= byte_index_next;
      phase      <= phase_next;
      type_word  <= type_word_next;
      tid_high   <= tid_high_next;
      tid_low    <= tid_low_next;
      attr_hdr   <= attr_hdr_next;
      value_rem  <= value_rem_next;
      pad_rem    <= pad_rem_next;
      in_user    <= in_user_next;
      err        <= err_next;
    end
  end

  // a second result is always the end status behind a first one
  a_second_is_status: assert property (@(posedge clk) disable iff (rst)
    push.vb |-> (push.va && push.b.kind == stun_hdr_pkg::KIND_STATUS))
    else $error("second result is not an end status");

  // end of packet restarts the header walk
  a_eop_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_packet) |=> (byte_index == '0 && phase == PH_HEADER))
    else $error("parser not restarted after end of packet");

  // overrun only recorded once the attribute walk has stopped
  a_err_done: assert property (@(posedge clk) disable iff (rst)
    err |-> (phase == PH_DONE))
    else $error("overrun flag set while still walking");

endmodule

/* hdl/stun_hdr_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stun_hdr_outq
// Four-entry result queue taking up to two results per cycle and
// presenting one registered result word at the output.
// ----------------------------------------------------------------------------
module stun_hdr_outq (
  input  logic                clk,
  input  logic                rst,
  input  stun_hdr_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output stun_hdr_pkg::res_t  head
);

  stun_hdr_pkg::res_t q [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt, cnt_next;
  logic       pop;
  logic [1:0] n_push;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != 3'd0);
  assign head      = q[rp];
  assign room      = (cnt <= 3'd2);
  assign n_push    = {1'b0, push.va} + {1'b0, push.vb};
  assign cnt_next  = cnt + {1'b0, n_push} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + n_push;
      rp  <= rp + {1'b0, pop};
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.va) begin
      q[wp] <= push.a;
    end
    if (push.vb) begin
      q[wp + 2'd1] <= push.b;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'd4)
    else $error("result queue overflow");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && !push.va) |=> (cnt == $past(cnt) - 3'd1))
    else $error("queue count wrong after pop");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.va |-> (cnt <= 3'd2))
    else $error("push without room");

endmodule

/* hdl/stun_header_attribute_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stun_header_attribute_parser
// STUN datagram parser: header fields, username attribute bytes, end status.
// ----------------------------------------------------------------------------
// Takes one datagram byte per word and accepts a new word every cycle while
// the result queue has room for two results; the parser state updates in the
// accepting cycle and its results are registered into a four-entry queue. A
// byte gives at most two results (header or username byte result plus end
// status if the end mark is on it); with the output side always ready the
// sustained rate is one byte per cycle. The user must write the username type
// register through the cfg port between datagrams; it is not enforced.
// ----------------------------------------------------------------------------
module stun_header_attribute_parser #(
  parameter int MAX_DATAGRAM = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic [11:0] packet_length,
  input  logic        end_of_packet,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] method,
  output logic [1:0]  msg_class,
  output logic [31:0] trans_id_upper,
  output logic [63:0] trans_id_lower,
  output logic [7:0]  username_byte,
  output logic        username_last,
  output logic [1:0]  status,
  output logic        last
);

  logic [15:0]         username_attr_type;
  logic                accept;
  stun_hdr_pkg::push_t push;
  stun_hdr_pkg::res_t  head;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      username_attr_type <= stun_hdr_pkg::USERNAME_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      username_attr_type <= cfg_data;
    end
  end

  stun_hdr_parse #(
    .MAX_DATAGRAM (MAX_DATAGRAM)
  ) u_parse (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .data_byte          (data_byte),
    .packet_length      (packet_length),
    .end_of_packet      (end_of_packet),
    .username_attr_type (username_attr_type),
    .push               (push)
  );

  stun_hdr_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign kind           = head.kind;
  assign method         = head.method;
  assign msg_class      = head.msg_class;
  assign trans_id_upper = head.trans_id_upper;
  assign trans_id_lower = head.trans_id_lower;
  assign username_byte  = head.username_byte;
  assign username_last  = head.username_last;
  assign status         = head.status;
  assign last           = head.last;

  // every accepted word with an end mark leaves at least one result behind
  a_eop_result: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_packet) |=> out_valid)
    else $error("no result after end of packet");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == stun_hdr_pkg::KIND_STATUS) |-> last)
    else $error("end status not marked last");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=> out_valid)
    else $error("input stalled with empty queue");

endmodule
